// File: sv/tile_dedup_table_assert.svh
// assertion macros for the tile deduplication table
`ifndef TILE_DEDUP_TABLE_ASSERT_SVH
`define TILE_DEDUP_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define TDT_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("tile dedup table: same-cycle check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define TDT_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("tile dedup table: next-cycle check failed");

`endif

// File: sv/tdt_pkg.sv
`default_nettype none

package tdt_pkg;

  // store depths
  localparam int unsigned DICT_DEPTH = 256;
  localparam int unsigned BACK_DEPTH = 64;

  // address, count and issue counter widths
  localparam int unsigned DICT_AW = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
  localparam int unsigned BACK_AW = (BACK_DEPTH > 1) ? $clog2(BACK_DEPTH) : 1;
  localparam int unsigned DICT_CW = $clog2(DICT_DEPTH + 1);
  localparam int unsigned BACK_CW = $clog2(BACK_DEPTH + 1);
  localparam int unsigned ISS_W   = (DICT_CW > BACK_CW) ? DICT_CW : BACK_CW;

  // field widths
  localparam int unsigned VIDX_W     = 9;
  localparam int unsigned PAT_W      = 64;
  localparam int unsigned KEY_W      = 2 * PAT_W;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned BG_ENTRY_W = KEY_W + VIDX_W;

  // opcodes
  localparam logic OP_PRELOAD = 1'b0;
  localparam logic OP_LOOKUP  = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DICT_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BACK_FULL = 2'd2;

endpackage

`default_nettype wire

// File: sv/tile_dedup_table.sv
// Tile deduplication table.
// Input channel (in_valid_i / in_stall_o) carries one item per transfer:
// opcode_i selects a background preload or a lookup, video_index_i is the
// slot for a preload, pattern_low_i / pattern_high_i form the 128-bit tile.
// Output channel (out_valid_o / out_stall_i) returns exactly one result per
// item: tile_index_o, from_background_o, newly_added_o and status_o.
// A preload goes straight from transfer to the response state, with no walk.
// A lookup walks the background store and then the dictionary through one
// shared 128-bit comparator, one entry per cycle from a registered-read
// memory; a miss walks both stores in full, and an early match ends the
// walk. in_stall_o is high while an item is in work. A finished result sits
// in the output register while the receiver stalls; the next item may be
// taken meanwhile, and its result waits inside the block until the output
// register frees.
// Reset clears both counts, so both stores start empty; no clearing pass.
`default_nettype none

`include "tile_dedup_table_assert.svh"

module tile_dedup_table (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         opcode_i,
  input  wire logic [tdt_pkg::VIDX_W-1:0]   video_index_i,
  input  wire logic [tdt_pkg::PAT_W-1:0]    pattern_low_i,
  input  wire logic [tdt_pkg::PAT_W-1:0]    pattern_high_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [tdt_pkg::VIDX_W-1:0]   tile_index_o,
  output logic                              from_background_o,
  output logic                              newly_added_o,
  output logic      [tdt_pkg::STATUS_W-1:0] status_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_BG   = 4'b0010,
    ST_DICT = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [tdt_pkg::ISS_W-1:0]   issue_q, issue_d;
  logic                        vld1_q, vld1_d;
  logic [tdt_pkg::DICT_AW-1:0] tag_q, tag_d;
  logic [tdt_pkg::DICT_CW-1:0] uniq_count_q, uniq_count_d;
  logic [tdt_pkg::BACK_CW-1:0] back_count_q, back_count_d;

  logic [tdt_pkg::VIDX_W-1:0]   res_idx_q, res_idx_d;
  logic                         res_bg_q, res_bg_d;
  logic                         res_add_q, res_add_d;
  logic [tdt_pkg::STATUS_W-1:0] res_status_q, res_status_d;

  logic out_valid_q, out_valid_d;
  logic out_load;

  logic in_accept;
  logic bg_we, bg_re, dict_we, dict_re, key_load;
  logic can_issue_bg, can_issue_dict;
  logic hit;

  logic [tdt_pkg::BG_ENTRY_W-1:0] bg_rdata;
  logic [tdt_pkg::KEY_W-1:0]      dict_rdata;
  logic [tdt_pkg::KEY_W-1:0]      cand;
  logic [tdt_pkg::KEY_W-1:0]      key;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // background store: {video index, high half, low half}
  tdt_ram #(
    .WIDTH (tdt_pkg::BG_ENTRY_W),
    .DEPTH (tdt_pkg::BACK_DEPTH)
  ) u_back_ram (
    .clk_i   (clk_i),
    .we_i    (bg_we),
    .waddr_i (back_count_q[tdt_pkg::BACK_AW-1:0]),
    .wdata_i ({video_index_i, pattern_high_i, pattern_low_i}),
    .re_i    (bg_re),
    .raddr_i (issue_q[tdt_pkg::BACK_AW-1:0]),
    .rdata_o (bg_rdata)
  );

  // dictionary of unique tiles
  tdt_ram #(
    .WIDTH (tdt_pkg::KEY_W),
    .DEPTH (tdt_pkg::DICT_DEPTH)
  ) u_dict_ram (
    .clk_i   (clk_i),
    .we_i    (dict_we),
    .waddr_i (uniq_count_q[tdt_pkg::DICT_AW-1:0]),
    .wdata_i (key),
    .re_i    (dict_re),
    .raddr_i (issue_q[tdt_pkg::DICT_AW-1:0]),
    .rdata_o (dict_rdata)
  );

  // shared comparator, fed from whichever store is being walked
  assign cand = (state_q == ST_DICT) ? dict_rdata : bg_rdata[tdt_pkg::KEY_W-1:0];

  tdt_cmp u_cmp (
    .clk_i      (clk_i),
    .load_i     (key_load),
    .key_low_i  (pattern_low_i),
    .key_high_i (pattern_high_i),
    .cand_i     (cand),
    .key_o      (key),
    .hit_o      (hit)
  );

  assign can_issue_bg   = (issue_q < tdt_pkg::ISS_W'(back_count_q));
  assign can_issue_dict = (issue_q < tdt_pkg::ISS_W'(uniq_count_q));

  // sequencer
  always_comb begin
    state_d      = state_q;
    issue_d      = issue_q;
    vld1_d       = 1'b0;
    tag_d        = tag_q;
    uniq_count_d = uniq_count_q;
    back_count_d = back_count_q;
    res_idx_d    = res_idx_q;
    res_bg_d     = res_bg_q;
    res_add_d    = res_add_q;
    res_status_d = res_status_q;
    bg_we        = 1'b0;
    bg_re        = 1'b0;
    dict_we      = 1'b0;
    dict_re      = 1'b0;
    key_load     = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (opcode_i == tdt_pkg::OP_PRELOAD) begin
            res_idx_d = video_index_i;
            res_bg_d  = 1'b0;
            res_add_d = 1'b0;
            if (back_count_q >= tdt_pkg::BACK_CW'(tdt_pkg::BACK_DEPTH)) begin
              res_status_d = tdt_pkg::STATUS_BACK_FULL;
            end else begin
              res_status_d = tdt_pkg::STATUS_OK;
              bg_we        = 1'b1;
              back_count_d = back_count_q + tdt_pkg::BACK_CW'(1);
            end
            state_d = ST_RESP;
          end else begin
            key_load = 1'b1;
            issue_d  = '0;
            state_d  = ST_BG;
          end
        end
      end
      ST_BG: begin
        if (vld1_q && hit) begin
          res_idx_d    = bg_rdata[tdt_pkg::BG_ENTRY_W-1:tdt_pkg::KEY_W];
          res_bg_d     = 1'b1;
          res_add_d    = 1'b0;
          res_status_d = tdt_pkg::STATUS_OK;
          state_d      = ST_RESP;
        end else if (can_issue_bg) begin
          bg_re   = 1'b1;
          issue_d = issue_q + tdt_pkg::ISS_W'(1);
          vld1_d  = 1'b1;
        end else if (!vld1_q) begin
          issue_d = '0;
          state_d = ST_DICT;
        end
      end
      ST_DICT: begin
        if (vld1_q && hit) begin
          res_idx_d    = tdt_pkg::VIDX_W'(tag_q);
          res_bg_d     = 1'b0;
          res_add_d    = 1'b0;
          res_status_d = tdt_pkg::STATUS_OK;
          state_d      = ST_RESP;
        end else if (can_issue_dict) begin
          dict_re = 1'b1;
          tag_d   = issue_q[tdt_pkg::DICT_AW-1:0];
          issue_d = issue_q + tdt_pkg::ISS_W'(1);
          vld1_d  = 1'b1;
        end else if (!vld1_q) begin
          res_bg_d = 1'b0;
          if (uniq_count_q >= tdt_pkg::DICT_CW'(tdt_pkg::DICT_DEPTH)) begin
            res_idx_d    = '0;
            res_add_d    = 1'b0;
            res_status_d = tdt_pkg::STATUS_DICT_FULL;
          end else begin
            dict_we      = 1'b1;
            res_idx_d    = tdt_pkg::VIDX_W'(uniq_count_q[tdt_pkg::DICT_AW-1:0]);
            res_add_d    = 1'b1;
            res_status_d = tdt_pkg::STATUS_OK;
            uniq_count_d = uniq_count_q + tdt_pkg::DICT_CW'(1);
          end
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && out_stall_i) || out_load;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      issue_q      <= '0;
      vld1_q       <= 1'b0;
      uniq_count_q <= '0;
      back_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      issue_q      <= issue_d;
      vld1_q       <= vld1_d;
      uniq_count_q <= uniq_count_d;
      back_count_q <= back_count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload: pending result and read tag
  always_ff @(posedge clk_i) begin
    tag_q        <= tag_d;
    res_idx_q    <= res_idx_d;
    res_bg_q     <= res_bg_d;
    res_add_q    <= res_add_d;
    res_status_q <= res_status_d;
  end

  // output register, loaded when the previous transfer has gone
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      tile_index_o      <= res_idx_q;
      from_background_o <= res_bg_q;
      newly_added_o     <= res_add_q;
      status_o          <= res_status_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  `TDT_ASSERT_NXT(a_busy_after_accept, in_accept, in_stall_o)
  `TDT_ASSERT_NXT(a_dict_grows_by_one, dict_we,
                  uniq_count_q == $past(uniq_count_q) + tdt_pkg::DICT_CW'(1))
  `TDT_ASSERT_NOW(a_read_only_in_walk, vld1_q, (state_q == ST_BG) || (state_q == ST_DICT))
  `TDT_ASSERT_NOW(a_no_store_past_full, dict_we,
                  uniq_count_q < tdt_pkg::DICT_CW'(tdt_pkg::DICT_DEPTH))

endmodule

`default_nettype wire

// File: sv/tdt_ram.sv
`default_nettype none

module tdt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: sv/tdt_cmp.sv
`default_nettype none

module tdt_cmp (
  input  wire logic                      clk_i,
  input  wire logic                      load_i,
  input  wire logic [tdt_pkg::PAT_W-1:0] key_low_i,
  input  wire logic [tdt_pkg::PAT_W-1:0] key_high_i,
  input  wire logic [tdt_pkg::KEY_W-1:0] cand_i,
  output logic      [tdt_pkg::KEY_W-1:0] key_o,
  output logic                           hit_o
);

  logic [tdt_pkg::KEY_W-1:0] key_q;

  // search key, held for the whole lookup
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      key_q <= {key_high_i, key_low_i};
    end
  end

  // full-width equality against the candidate entry
  assign hit_o = (cand_i == key_q);
  assign key_o = key_q;

endmodule

`default_nettype wire

// File: tb/sv/tile_dedup_table_test.sv
`timescale 1ns / 100ps

module tile_dedup_table_test;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_ITEMS   = 1855;
  localparam int CALM_FIRST     = 300;
  localparam int CALM_LAST      = 600;
  localparam int PAUSE_AT       = 1000;
  localparam int DRAIN_CYCLES   = 400;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [tdt_pkg::VIDX_W-1:0]   tile_index;
    logic                         from_background;
    logic                         newly_added;
    logic [tdt_pkg::STATUS_W-1:0] status;
  } tile_answer_t;

  // tile dictionary predictor and queue of expected answers
  class dedup_ledger;
    logic [tdt_pkg::PAT_W-1:0]  dict_low   [tdt_pkg::DICT_DEPTH];
    logic [tdt_pkg::PAT_W-1:0]  dict_high  [tdt_pkg::DICT_DEPTH];
    logic [tdt_pkg::PAT_W-1:0]  back_low   [tdt_pkg::BACK_DEPTH];
    logic [tdt_pkg::PAT_W-1:0]  back_high  [tdt_pkg::BACK_DEPTH];
    logic [tdt_pkg::VIDX_W-1:0] back_video [tdt_pkg::BACK_DEPTH];
    int unsigned                dict_count;
    int unsigned                back_count;
    int unsigned                error_count;
    tile_answer_t               answer_q [$];

    function new();
      dict_count  = 0;
      back_count  = 0;
      error_count = 0;
    endfunction

    task report_mismatch(string what);
      error_count++;
      $display("%0.1f ns: result error: %s", $realtime, what);
    endtask

    // work out the answer to one accepted item and update the stores
    function void note_item(logic op, logic [tdt_pkg::VIDX_W-1:0] vidx,
                            logic [tdt_pkg::PAT_W-1:0] lo, logic [tdt_pkg::PAT_W-1:0] hi);
      tile_answer_t ans;
      bit           hit;
      int unsigned  k;
      ans = '0;
      hit = 1'b0;
      if (op == tdt_pkg::OP_PRELOAD) begin
        ans.tile_index = vidx;
        if (back_count >= tdt_pkg::BACK_DEPTH) begin
          ans.status = tdt_pkg::STATUS_BACK_FULL;
        end else begin
          back_low[back_count]   = lo;
          back_high[back_count]  = hi;
          back_video[back_count] = vidx;
          back_count++;
        end
      end else begin
        // background entries first, in load order
        for (k = 0; k < back_count && !hit; k++) begin
          if (back_low[k] == lo && back_high[k] == hi) begin
            ans.tile_index      = back_video[k];
            ans.from_background = 1'b1;
            hit = 1'b1;
          end
        end
        // then the unique tiles, in insertion order
        for (k = 0; k < dict_count && !hit; k++) begin
          if (dict_low[k] == lo && dict_high[k] == hi) begin
            ans.tile_index = tdt_pkg::VIDX_W'(k);
            hit = 1'b1;
          end
        end
        // miss: append if there is room
        if (!hit) begin
          if (dict_count >= tdt_pkg::DICT_DEPTH) begin
            ans.status = tdt_pkg::STATUS_DICT_FULL;
          end else begin
            dict_low[dict_count]  = lo;
            dict_high[dict_count] = hi;
            ans.tile_index  = tdt_pkg::VIDX_W'(dict_count);
            ans.newly_added = 1'b1;
            dict_count++;
          end
        end
      end
      answer_q = {answer_q, ans};
    endfunction

    task check_answer(tile_answer_t got);
      tile_answer_t exp_ans;
      if (answer_q.size() == 0) begin
        report_mismatch($sformatf("idx %0d bg %0b new %0b st %0d with nothing outstanding",
                                  got.tile_index, got.from_background, got.newly_added,
                                  got.status));
      end else begin
        exp_ans = answer_q.pop_front();
        if (got !== exp_ans) begin
          report_mismatch($sformatf({"got idx %0d bg %0b new %0b st %0d, ",
                                     "wanted idx %0d bg %0b new %0b st %0d"},
                                    got.tile_index, got.from_background, got.newly_added,
                                    got.status, exp_ans.tile_index, exp_ans.from_background,
                                    exp_ans.newly_added, exp_ans.status));
        end
      end
    endtask
  endclass

  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         in_valid_i     = 1'b0;
  logic                         opcode_i       = tdt_pkg::OP_LOOKUP;
  logic [tdt_pkg::VIDX_W-1:0]   video_index_i  = '0;
  logic [tdt_pkg::PAT_W-1:0]    pattern_low_i  = '0;
  logic [tdt_pkg::PAT_W-1:0]    pattern_high_i = '0;
  logic                         out_stall_i    = 1'b0;
  logic                         in_stall_o;
  logic                         out_valid_o;
  logic [tdt_pkg::VIDX_W-1:0]   tile_index_o;
  logic                         from_background_o;
  logic                         newly_added_o;
  logic [tdt_pkg::STATUS_W-1:0] status_o;

  dedup_ledger   ledger;
  bit            calm = 1'b0;
  int unsigned   quiet_cycles = 0;
  logic [tdt_pkg::KEY_W-1:0] seen_q [$];

  tile_dedup_table DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .video_index_i    (video_index_i),
    .pattern_low_i    (pattern_low_i),
    .pattern_high_i   (pattern_high_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .tile_index_o     (tile_index_o),
    .from_background_o(from_background_o),
    .newly_added_o    (newly_added_o),
    .status_o         (status_o)
  );

  // clock
  always #CLK_HALF clk_i = ~clk_i;

  // receiver stalls at random, except in the calm stretch
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 35);
  end

  // transfer monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        ledger.note_item(opcode_i, video_index_i, pattern_low_i, pattern_high_i);
      end
      if (out_valid_o && !out_stall_i) begin
        ledger.check_answer({tile_index_o, from_background_o, newly_added_o, status_o});
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // offer one item and hold it until the transfer
  task automatic send_item(logic op, logic [tdt_pkg::VIDX_W-1:0] vidx,
                           logic [tdt_pkg::KEY_W-1:0] pat);
    while (!calm && $urandom_range(0, 99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    video_index_i  <= vidx;
    pattern_low_i  <= pat[tdt_pkg::PAT_W-1:0];
    pattern_high_i <= pat[tdt_pkg::KEY_W-1:tdt_pkg::PAT_W];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic logic [tdt_pkg::KEY_W-1:0] random_pattern();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  initial begin
    int unsigned               n;
    int unsigned               roll;
    int unsigned               pick;
    int unsigned               bitpos;
    logic                      op;
    logic [tdt_pkg::KEY_W-1:0] pat;
    logic [tdt_pkg::KEY_W-1:0] alt_a;
    logic [tdt_pkg::KEY_W-1:0] alt_b;

    ledger = new();
    alt_a  = {64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};
    alt_b  = {64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555};
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty stores, extremes, background precedence, repeats
    send_item(tdt_pkg::OP_LOOKUP,  9'd0,   '0);
    send_item(tdt_pkg::OP_LOOKUP,  9'd511, '1);
    send_item(tdt_pkg::OP_LOOKUP,  9'd0,   '0);
    send_item(tdt_pkg::OP_PRELOAD, 9'd511, '1);
    send_item(tdt_pkg::OP_LOOKUP,  9'd0,   '1);
    send_item(tdt_pkg::OP_PRELOAD, 9'd0,   alt_a);
    // same video index again with another pattern
    send_item(tdt_pkg::OP_PRELOAD, 9'd0,   alt_b);
    // same pattern again at a later position, first one wins
    send_item(tdt_pkg::OP_PRELOAD, 9'd300, alt_a);
    send_item(tdt_pkg::OP_LOOKUP,  9'd511, alt_a);
    send_item(tdt_pkg::OP_LOOKUP,  9'd1,   alt_b);
    send_item(tdt_pkg::OP_LOOKUP,  9'd2,   {64'd0, 64'd1});
    send_item(tdt_pkg::OP_LOOKUP,  9'd3,   {64'h8000_0000_0000_0000, 64'd0});
    send_item(tdt_pkg::OP_LOOKUP,  9'd4,   {64'd0, 64'd1});
    send_item(tdt_pkg::OP_LOOKUP,  9'd5,   {64'd0, 64'h8000_0000_0000_0000});
    send_item(tdt_pkg::OP_LOOKUP,  9'd6,   {64'd1, 64'd0});
    send_item(tdt_pkg::OP_LOOKUP,  9'd7,   {64'h8000_0000_0000_0000, 64'd0});

    // random: fresh tiles, repeats of known tiles and near misses
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= CALM_FIRST && n < CALM_LAST);
      if (n == PAUSE_AT) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (ledger.answer_q.size() != 0);
      end
      roll = $urandom_range(0, 99);
      op   = (roll < 12) ? tdt_pkg::OP_PRELOAD : tdt_pkg::OP_LOOKUP;
      pick = $urandom_range(0, 99);
      if (seen_q.size() == 0 || pick < 40) begin
        pat = random_pattern();
        seen_q = {seen_q, pat};
      end else begin
        pat = seen_q[$urandom_range(0, seen_q.size() - 1)];
        if (pick >= 85) begin
          bitpos = $urandom_range(0, tdt_pkg::KEY_W - 1);
          pat[bitpos] = ~pat[bitpos];
          seen_q = {seen_q, pat};
        end
      end
      send_item(op, tdt_pkg::VIDX_W'($urandom_range(0, 511)), pat);
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    // drain and settle, after the last transfer has been noted
    @(posedge clk_i);
    while (ledger.answer_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (ledger.error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: tile_dedup_table.f
+incdir+sv
sv/tdt_pkg.sv
sv/tdt_ram.sv
sv/tdt_cmp.sv
sv/tile_dedup_table.sv
tb/sv/tile_dedup_table_test.sv
